>>> sv/pch_pkg.sv
// ----------------------------------------------------------------------------
// pch_pkg: shared types and constants of the pulse centred histogram
// Result codes, register indexes, register reset values and default sizes.
// ----------------------------------------------------------------------------
package pch_pkg;

  // default sizes
  localparam int MAX_SEGMENT_DEF = 1024;
  localparam int HIST_LEN_DEF    = 1024;
  localparam int MAX_ROWS_DEF    = 32;

  // fixed field widths
  localparam int CENT_W = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // result codes
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_SEVERAL  = 3'd1;
  localparam logic [2:0] ST_TOO_WIDE = 3'd2;
  localparam logic [2:0] ST_OUT_BINS = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 3'd5;

  // register reset values
  localparam logic signed [7:0] THRESHOLD_RST  = -8'sd110;
  localparam logic signed [7:0] BACKGROUND_RST = -8'sd115;
  localparam logic [15:0]       BINS_PER_RST   = 16'd3840;
  localparam logic [10:0]       HIST_LEN_RST   = 11'd1001;
  localparam logic [5:0]        MAX_WIDTH_RST  = 6'd20;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/pulse_centred_histogram.sv
// ----------------------------------------------------------------------------
// pulse_centred_histogram: weighted pulse centroid and histogram accumulator
// Gathers one waveform segment, finds its centroid and adds its samples
// into a two band histogram that read beats return.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall): kind 0 beats are samples, last marks
//  the segment end; kind 1 beats read one histogram entry. Output channel
//  (out_valid/out_stall) returns one beat per read and per segment end.
//  Config channel (cfg_valid/cfg_ready) is always ready; write only when idle.
//  Throughput: samples without last are taken one per cycle while in_stall is
//  low. A read stalls the input until its registered histogram read is loaded
//  into the output register. A segment end forms the centroid (bit-serial
//  divider, NW = numerator width, 39 at default sizes; skipped when the weight
//  sum is zero), then, unless the segment has several pulses or is too wide,
//  reads and multiplies each stored sample, adds, bins and read-modify-writes
//  those above threshold whose bin is kept, and loads the output register.
//  Reset: configuration returns to defaults, then a clearing pass writes one
//  histogram entry per cycle over all 2*MAX_ROWS*HIST_LEN entries (65536 at
//  default sizes), with in_stall high.
//  When the receiver stalls, the result is held in the output register; the
//  block keeps taking samples and holds the next result until it is taken.
// ----------------------------------------------------------------------------
module pulse_centred_histogram #(
  parameter int MAX_SEGMENT = pch_pkg::MAX_SEGMENT_DEF,
  parameter int HIST_LEN    = pch_pkg::HIST_LEN_DEF,
  parameter int MAX_ROWS    = pch_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             kind,
  input  logic                             band,
  input  logic signed [7:0]                sample,
  input  logic                             last,
  input  logic [4:0]                       read_row,
  input  logic [9:0]                       read_bin,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       status,
  output logic [4:0]                       row_used,
  output logic [pch_pkg::CENT_W-1:0]       centroid,
  output logic [31:0]                      hist_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pch_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pch_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pch_pkg::*;

  localparam int IW    = $clog2(MAX_SEGMENT);
  localparam int CW    = $clog2(MAX_SEGMENT + 1);
  localparam int WIS_W = IW + 8 + CW;
  localparam int WS_W  = 8 + CW;
  localparam int NW    = WIS_W + 10;
  localparam int DW    = WS_W + 1;
  localparam int DEPTH = 2 * MAX_ROWS * HIST_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int DFW   = (IW + 8 > CENT_W) ? IW + 9 : CENT_W + 1;
  localparam int PW    = DFW + 17;
  localparam int VW    = (PW > 27) ? PW + 1 : 28;
  localparam int QW    = VW - 16;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_OUT, S_DIV_GO, S_DIV, S_DECIDE,
    S_SEG, S_MUL, S_ADD, S_BIN, S_UPD, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic signed [7:0] threshold;
  logic signed [7:0] background;
  logic [15:0]       bins_per_sample;
  logic [10:0]       hist_length;
  logic [5:0]        max_width;
  logic              width_indexing;

  // segment running state
  logic [CW-1:0]    seg_count;
  logic [WIS_W-1:0] wis;
  logic [WS_W-1:0]  ws;
  logic [CW-1:0]    above;
  logic [1:0]       feat;
  logic             in_pulse;
  logic             band_r;

  // end pass
  logic [CENT_W-1:0]   cent_r;
  logic [CW-1:0]       row_r;
  logic [2:0]          st_r;
  logic [CW-1:0]       pass_i;
  logic signed [PW-1:0] prod_r;
  logic signed [VW-1:0] v_r;
  logic [7:0]          w_r;
  logic [AW-1:0]       upd_addr;
  logic [AW-1:0]       clr_addr;
  logic                rd_zero;

  // memories
  logic [7:0]    seg_mem [MAX_SEGMENT];
  logic [7:0]    seg_q;
  logic          hist_re;
  logic [AW-1:0] hist_raddr;
  logic [31:0]   hist_q;
  logic          hist_we;
  logic [AW-1:0] hist_waddr;
  logic [31:0]   hist_wdata;

  // divider
  logic               div_start;
  logic [NW-1:0]      div_num;
  logic [DW-1:0]      div_den;
  logic [CENT_W-1:0]  div_q;
  div_stat_t          dstat;

  // combinational helpers
  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic                smp_acc;
  logic                smp_keep;
  logic signed [8:0]   acc_diff;
  logic [7:0]          acc_w;
  logic                acc_above;
  logic signed [8:0]   pas_diff;
  logic [7:0]          pas_w;
  logic signed [DFW-1:0] pos_diff;
  logic                v_neg;
  logic [VW-1:0]       v_mag;
  logic [QW-1:0]       q_mag;
  logic [QW-1:0]       bin_val;
  logic [12:0]         limit;
  logic                bin_oor;
  logic [AW-1:0]       rd_addr;
  logic                rd_in_range;
  logic [AW-1:0]       bin_addr;
  logic [32:0]         sat_sum;
  logic                pass_end;
  logic                too_wide;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = ((state == S_RD_OUT) || (state == S_FIN)) && out_free;
  assign smp_acc   = in_acc && !kind;
  assign smp_keep  = smp_acc && (32'(seg_count) < MAX_SEGMENT);

  // weight of an arriving sample
  always_comb begin
    acc_diff  = 9'(sample) - 9'(background);
    acc_w     = (acc_diff > 9'sd0) ? acc_diff[7:0] : 8'd0;
    acc_above = sample > threshold;
  end

  // end pass arithmetic
  always_comb begin
    pas_diff = 9'($signed(seg_q)) - 9'(background);
    pas_w    = (pas_diff > 9'sd0) ? pas_diff[7:0] : 8'd0;
    pos_diff = $signed(DFW'({pass_i[IW-1:0], 8'd0})) - $signed(DFW'(cent_r));
    v_neg    = v_r[VW-1];
    v_mag    = v_neg ? VW'(-v_r) : VW'(v_r);
    q_mag    = v_mag[VW-1:16];
    bin_val  = v_neg ? '0 : q_mag;
    limit    = (32'(hist_length) < HIST_LEN) ? 13'(hist_length) : 13'(HIST_LEN);
    bin_oor  = (v_neg && (q_mag != '0)) || (bin_val >= QW'(limit));
    bin_addr = AW'((32'(band_r) * MAX_ROWS + 32'(row_r)) * HIST_LEN + 32'(bin_val));
    sat_sum  = {1'b0, hist_q} + 33'(w_r);
    pass_end = (pass_i + 1'b1) == seg_count;
    too_wide = width_indexing &&
               ((32'(above) >= 32'(max_width)) || (32'(above) >= MAX_ROWS));
    rd_in_range = (32'(read_row) < MAX_ROWS) && (32'(read_bin) < HIST_LEN);
    rd_addr  = AW'((32'(band) * MAX_ROWS + 32'(read_row)) * HIST_LEN + 32'(read_bin));
  end

  // histogram port selection
  always_comb begin
    hist_re    = 1'b0;
    hist_raddr = rd_addr;
    if (state == S_IDLE && in_acc && kind && rd_in_range) begin
      hist_re = 1'b1;
    end else if (state == S_BIN && !bin_oor) begin
      hist_re    = 1'b1;
      hist_raddr = bin_addr;
    end
    hist_we    = (state == S_CLEAR) || (state == S_UPD);
    hist_waddr = (state == S_CLEAR) ? clr_addr : upd_addr;
    hist_wdata = (state == S_CLEAR) ? 32'd0 :
                 (sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0]);
  end

  // divider operands: (512*sum + ws) / (2*ws)
  assign div_start = (state == S_DIV_GO) && (ws != '0);
  assign div_num   = {wis, 9'd0} + NW'(ws);
  assign div_den   = {ws, 1'b0};

  pch_divider #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_q),
    .stat  (dstat)
  );

  pch_hist_mem #(.DEPTH(DEPTH), .AW(AW)) u_hist (
    .clk   (clk),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_q),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata)
  );

  // segment store
  always_ff @(posedge clk) begin
    if (smp_keep) begin
      seg_mem[seg_count[IW-1:0]] <= sample;
    end
    seg_q <= seg_mem[pass_i[IW-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= THRESHOLD_RST;
      background      <= BACKGROUND_RST;
      bins_per_sample <= BINS_PER_RST;
      hist_length     <= HIST_LEN_RST;
      max_width       <= MAX_WIDTH_RST;
      width_indexing  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD:  threshold       <= cfg_data[7:0];
        CFG_BACKGROUND: background      <= cfg_data[7:0];
        CFG_BINS_PER:   bins_per_sample <= cfg_data;
        CFG_HIST_LEN:   hist_length     <= cfg_data[10:0];
        CFG_MAX_WIDTH:  max_width       <= cfg_data[5:0];
        CFG_WIDTH_IDX:  width_indexing  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control, segment sums and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      seg_count <= '0;
      wis       <= '0;
      ws        <= '0;
      above     <= '0;
      feat      <= '0;
      in_pulse  <= 1'b0;
      pass_i    <= '0;
    end else begin
      // load a new result or release a taken one
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && kind) begin
            rd_zero <= !rd_in_range;
            row_r   <= CW'(read_row);
            state   <= S_RD_OUT;
          end else if (smp_acc) begin
            if (smp_keep) begin
              seg_count <= seg_count + 1'b1;
              if (acc_above) begin
                wis      <= wis + (WIS_W'(seg_count[IW-1:0]) * WIS_W'(acc_w));
                ws       <= ws + WS_W'(acc_w);
                above    <= above + 1'b1;
                in_pulse <= 1'b1;
              end else if (in_pulse) begin
                feat     <= (feat == 2'd2) ? 2'd2 : feat + 2'd1;
                in_pulse <= 1'b0;
              end
            end
            if (last) begin
              band_r <= band;
              state  <= S_DIV_GO;
            end
          end
        end
        S_RD_OUT: begin
          if (out_free) begin
            status     <= ST_READ;
            row_used   <= row_r[4:0];
            centroid   <= '0;
            hist_value <= rd_zero ? 32'd0 : hist_q;
            state      <= S_IDLE;
          end
        end
        S_DIV_GO: begin
          cent_r <= '0;
          state  <= (ws == '0) ? S_DECIDE : S_DIV;
        end
        S_DIV: begin
          if (dstat.done) begin
            cent_r <= div_q;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          pass_i <= '0;
          if (feat == 2'd2) begin
            row_r <= '0;
            st_r  <= ST_SEVERAL;
            state <= S_FIN;
          end else if (too_wide) begin
            row_r <= '0;
            st_r  <= ST_TOO_WIDE;
            state <= S_FIN;
          end else begin
            row_r <= width_indexing ? above : '0;
            st_r  <= ST_ADDED;
            state <= (seg_count == '0) ? S_FIN : S_SEG;
          end
        end
        S_SEG: begin
          state <= S_MUL;
        end
        S_MUL: begin
          w_r    <= pas_w;
          prod_r <= pos_diff * $signed({1'b0, bins_per_sample});
          if ($signed(seg_q) > threshold) begin
            state <= S_ADD;
          end else begin
            pass_i <= pass_i + 1'b1;
            state  <= pass_end ? S_FIN : S_SEG;
          end
        end
        S_ADD: begin
          v_r   <= VW'(prod_r) + $signed(VW'({hist_length, 15'd0}));
          state <= S_BIN;
        end
        S_BIN: begin
          upd_addr <= bin_addr;
          if (bin_oor) begin
            st_r   <= ST_OUT_BINS;
            pass_i <= pass_i + 1'b1;
            state  <= pass_end ? S_FIN : S_SEG;
          end else begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          pass_i <= pass_i + 1'b1;
          state  <= pass_end ? S_FIN : S_SEG;
        end
        S_FIN: begin
          if (out_free) begin
            status     <= st_r;
            row_used   <= row_r[4:0];
            centroid   <= cent_r;
            hist_value <= 32'd0;
            seg_count  <= '0;
            wis        <= '0;
            ws         <= '0;
            above      <= '0;
            feat       <= '0;
            in_pulse   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // histogram writes only from the clearing pass or the update step
  a_hist_we: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> (state == S_CLEAR || state == S_UPD))
    else $error("histogram write outside clear or update");

  // divider finishes only while the control waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> (state == S_DIV))
    else $error("divider done outside divide state");

  // read results never carry a centroid, segment results never a value
  a_out_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == ST_READ) ? (centroid == '0) : (hist_value == 32'd0)))
    else $error("result fields mixed");

  // segment count stays within the store
  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    32'(seg_count) <= MAX_SEGMENT)
    else $error("segment count beyond store");

  // update step always follows a histogram read
  a_upd_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> $past(hist_re))
    else $error("update without read");
`endif

endmodule

>>> sv/pch_divider.sv
// ----------------------------------------------------------------------------
// pch_divider: restoring divider, one quotient bit per cycle
// Keeps the low CENT_W bits of the quotient; done pulses after the last of the NW trial subtractions.
// ----------------------------------------------------------------------------
module pch_divider #(
  parameter int NW = 42,
  parameter int DW = 21
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NW-1:0]             num,
  input  logic [DW-1:0]             den,
  output logic [pch_pkg::CENT_W-1:0] quot,
  output pch_pkg::div_stat_t        stat
);
  import pch_pkg::*;

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   numsh;
  logic [DW-1:0]   rem;
  logic            busy;
  logic            done;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_nx;
  logic            fits;

  // one trial subtraction
  always_comb begin
    rem_sh = {rem, numsh[NW-1]};
    fits   = rem_sh >= {1'b0, den};
    rem_nx = fits ? (rem_sh - {1'b0, den}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNTW'(NW);
        numsh <= num;
        rem   <= '0;
      end else if (busy) begin
        numsh <= {numsh[NW-2:0], 1'b0};
        rem   <= rem_nx[DW-1:0];
        quot  <= {quot[CENT_W-2:0], fits};
        cnt   <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

>>> sv/pch_hist_mem.sv
// ----------------------------------------------------------------------------
// pch_hist_mem: histogram store, one write and one registered read port
// ----------------------------------------------------------------------------
module pch_hist_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
